@@ rtl/core/mpdwf_pkg.sv @@
// Shared types and constants for the minimum positive depth window filter.
`default_nettype none

package mpdwf_pkg;

	// Field widths fixed by the pixel format
	localparam int DEPTH_BITS  = 16;
	localparam int NORMAL_BITS = 16;

	// Default sizing of the line buffers and window
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 3;

	// Frame height limit
	localparam int MAX_HEIGHT = 1024;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 11;
	localparam int RADIUS_BITS    = 2;
	localparam int DIM_BITS       = 11;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);
	localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = DIM_BITS'(640);
	localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = DIM_BITS'(480);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_KERNEL_RADIUS = 2'd0,
		CFG_IMAGE_WIDTH   = 2'd1,
		CFG_IMAGE_HEIGHT  = 2'd2
	} cfg_reg_t;

	// One stored pixel: depth plus normal
	typedef struct packed {
		logic        [DEPTH_BITS-1:0]  depth;
		logic signed [NORMAL_BITS-1:0] nx;
		logic signed [NORMAL_BITS-1:0] ny;
		logic signed [NORMAL_BITS-1:0] nz;
	} pixel_t;

	localparam int PIXEL_BITS = $bits(pixel_t);

	// Input transaction payload
	typedef struct packed {
		logic        [DEPTH_BITS-1:0]  depth_in;
		logic signed [NORMAL_BITS-1:0] normal_x_in;
		logic signed [NORMAL_BITS-1:0] normal_y_in;
		logic signed [NORMAL_BITS-1:0] normal_z_in;
		logic                          is_padding;
	} px_item_t;

	// Result transaction payload
	typedef struct packed {
		logic        [DEPTH_BITS-1:0]  depth_out;
		logic signed [NORMAL_BITS-1:0] normal_x_out;
		logic signed [NORMAL_BITS-1:0] normal_y_out;
		logic signed [NORMAL_BITS-1:0] normal_z_out;
		logic                          frame_last;
	} res_item_t;

	// Per-item control flags that travel down the pipeline
	typedef struct packed {
		logic emit;   // item completes a window, a result follows
		logic last;   // result belongs to the frame's final pixel
		logic pass;   // radius zero: centre pixel goes out unchanged
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/min_positive_depth_window_filter_unit.sv @@
// Top level of the minimum positive depth window filter.
//
// Takes one depth pixel with its normal per clock in raster order and, for each
// centre pixel, returns the smallest non-zero depth in a (2r+1) x (2r+1) window
// clipped at the frame borders, with the normal of that pixel (earliest in scan
// order on a tie, all zero if the window holds no valid depth). Radius 0 passes
// pixels through. A transaction is taken every clock when the result side keeps
// up; the result for pixel q belongs to the transaction that carries pixel
// q + r*width + r, so r rows plus r pixels of padding must follow the frame to
// flush it, and that transaction passes stages s1, s2, s3 and the result
// register before res_valid rises. The filter holds 2*MAX_RADIUS line buffers
// of MAX_WIDTH pixels, each read and written once per pixel, and the window
// registers behind them. Line buffer contents need no clearing:
// pixels outside the frame are masked. A register write restarts the frame and
// must only be made while the pipeline is empty.
`default_nettype none

module min_positive_depth_window_filter_unit
	import mpdwf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      px_valid,
	output logic                           px_ready,
	input  wire px_item_t                  px_data,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output res_item_t                      res_data,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int CIW = $clog2(MAX_WIDTH);

	logic                      accept;
	logic [CIW-1:0]            rd_col;
	pixel_t                    pix;
	ctl_t                      ctl;
	logic [WIN-1:0]            rowm, colm;
	logic                      free_s3;
	logic                      v_s2;
	pixel_t [WIN-1:0][WIN-1:0] win;
	ctl_t                      ctl_s2;
	logic [WIN-1:0]            rowm_s2, colm_s2;

	assign accept = px_valid && px_ready;

	// Configuration and frame cursors
	mpdwf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (px_data),
		.accept    (accept),
		.rd_col    (rd_col),
		.pix       (pix),
		.ctl       (ctl),
		.rowm      (rowm),
		.colm      (colm)
	);

	// Line buffers and window
	mpdwf_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rd_col  (rd_col),
		.pix     (pix),
		.ctl     (ctl),
		.rowm    (rowm),
		.colm    (colm),
		.free_s3 (free_s3),
		.ready   (px_ready),
		.v_s2    (v_s2),
		.win     (win),
		.ctl_s2  (ctl_s2),
		.rowm_s2 (rowm_s2),
		.colm_s2 (colm_s2)
	);

	// Minimum search and result register
	mpdwf_select #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s2      (v_s2),
		.win       (win),
		.ctl_s2    (ctl_s2),
		.rowm_s2   (rowm_s2),
		.colm_s2   (colm_s2),
		.free_s3   (free_s3),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

@@ rtl/core/mpdwf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mpdwf_ram
	import mpdwf_pkg::*;
#(
	parameter int WIDTH = PIXEL_BITS,
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when both ports hit one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mpdwf_ctrl.sv @@
// Configuration registers, frame cursors and window clipping masks.
`default_nettype none

module mpdwf_ctrl
	import mpdwf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  wire px_item_t                      item,
	input  wire logic                          accept,
	output logic [$clog2(MAX_WIDTH)-1:0]       rd_col,
	output pixel_t                             pix,
	output ctl_t                               ctl,
	output logic [2*MAX_RADIUS:0]              rowm,
	output logic [2*MAX_RADIUS:0]              colm
);

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RIW = $clog2(MAX_HEIGHT);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

	// Configuration registers
	logic [RADIUS_BITS-1:0] radius_q;
	logic [DIM_BITS-1:0]    width_q;
	logic [DIM_BITS-1:0]    height_q;

	// Input cursor, output cursor and fill count
	logic [CIW-1:0] in_col_q, in_col_d;
	logic [RIW-1:0] in_row_q, in_row_d;
	logic           in_done_q, in_done_d;
	logic [LW-1:0]  fill_q, fill_d;
	logic [CIW-1:0] o_col_q, o_col_d;
	logic [RIW-1:0] o_row_q, o_row_d;

	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [RW-1:0]    rad_eff;
	logic [RW+WW-1:0] lag_prod;
	logic [LW-1:0]    lag;
	logic             cfg_hit;
	logic             in_col_last, in_row_last;
	logic             o_col_last, o_row_last;
	logic             emit, frame_end, pad;
	logic [HW:0]      row_sum;
	logic [WW:0]      col_sum;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_KERNEL_RADIUS ||
		cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	// Effective frame geometry: zero reads as one, oversize is clamped to the limits
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			rad_eff = RW'(MAX_RADIUS);
		end else begin
			rad_eff = RW'(radius_q);
		end
		lag_prod = (RW+WW)'(rad_eff) * (RW+WW)'(w_eff);
		lag      = LW'(lag_prod) + LW'(rad_eff);
	end

	// Cursor stepping for the item on the input
	always_comb begin
		in_col_last = (WW'(in_col_q) == w_eff - WW'(1));
		in_row_last = (HW'(in_row_q) == h_eff - HW'(1));
		o_col_last  = (WW'(o_col_q) == w_eff - WW'(1));
		o_row_last  = (HW'(o_row_q) == h_eff - HW'(1));
		emit        = (fill_q == lag);
		frame_end   = emit && o_col_last && o_row_last;

		in_col_d  = in_col_last ? '0 : in_col_q + CIW'(1);
		in_row_d  = in_row_q;
		in_done_d = in_done_q;
		if (!in_done_q && in_col_last) begin
			if (in_row_last) begin
				in_done_d = 1'b1;
			end else begin
				in_row_d = in_row_q + RIW'(1);
			end
		end
		fill_d  = emit ? fill_q : fill_q + LW'(1);
		o_col_d = o_col_q;
		o_row_d = o_row_q;
		if (emit) begin
			o_col_d = o_col_last ? '0 : o_col_q + CIW'(1);
			if (o_col_last) begin
				o_row_d = o_row_q + RIW'(1);
			end
		end
		// Final result of the frame returns every cursor to the start
		if (frame_end) begin
			in_col_d  = '0;
			in_row_d  = '0;
			in_done_d = 1'b0;
			fill_d    = '0;
			o_col_d   = '0;
			o_row_d   = '0;
		end
	end

	// Item payload: padding and pixels beyond the frame store as zero
	always_comb begin
		pad    = item.is_padding || in_done_q;
		rd_col = in_col_q;
		if (pad) begin
			pix = '0;
		end else begin
			pix.depth = item.depth_in;
			pix.nx    = item.normal_x_in;
			pix.ny    = item.normal_y_in;
			pix.nz    = item.normal_z_in;
		end
		ctl.emit = emit;
		ctl.last = frame_end;
		ctl.pass = (rad_eff == '0);
	end

	// Clipping masks; index is the age of a window row or column
	always_comb begin
		row_sum = (HW+1)'(o_row_q) + (HW+1)'(rad_eff);
		col_sum = (WW+1)'(o_col_q) + (WW+1)'(rad_eff);
		for (int k = 0; k < WIN; k++) begin
			rowm[k] = (k <= 2 * int'(rad_eff)) && (row_sum >= (HW+1)'(k)) &&
				(row_sum < (HW+1)'(h_eff) + (HW+1)'(k));
			colm[k] = (k <= 2 * int'(rad_eff)) && (col_sum >= (WW+1)'(k)) &&
				(col_sum < (WW+1)'(w_eff) + (WW+1)'(k));
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KERNEL_RADIUS: radius_q <= RADIUS_BITS'(cfg_data);
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Cursors: a register write aborts the frame in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			fill_q    <= '0;
			o_col_q   <= '0;
			o_row_q   <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			fill_q    <= '0;
			o_col_q   <= '0;
			o_row_q   <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			in_done_q <= in_done_d;
			fill_q    <= fill_d;
			o_col_q   <= o_col_d;
			o_row_q   <= o_row_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mpdwf_window.sv @@
// Line buffers and the sliding window registers (stages s1 and s2).
`default_nettype none

module mpdwf_window
	import mpdwf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]        rd_col,
	input  wire pixel_t                              pix,
	input  wire ctl_t                                ctl,
	input  wire logic [2*MAX_RADIUS:0]               rowm,
	input  wire logic [2*MAX_RADIUS:0]               colm,
	input  wire logic                                free_s3,
	output logic                                     ready,
	output logic                                     v_s2,
	output pixel_t [2*MAX_RADIUS:0][2*MAX_RADIUS:0]  win,
	output ctl_t                                     ctl_s2,
	output logic [2*MAX_RADIUS:0]                    rowm_s2,
	output logic [2*MAX_RADIUS:0]                    colm_s2
);

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int NLB = 2 * MAX_RADIUS;
	localparam int CIW = $clog2(MAX_WIDTH);

	// Stage s1: accepted pixel waiting for its line buffer column
	logic           v_s1_q;
	pixel_t         pix_s1;
	logic [CIW-1:0] col_s1;
	logic           fwd_s1;
	ctl_t           ctl_s1;
	logic [WIN-1:0] rowm_s1;
	logic [WIN-1:0] colm_s1;

	// Stage s2: window registers, win_q[column age][row age]
	logic                       v_s2_q;
	pixel_t [WIN-1:0][WIN-1:0]  win_q;

	logic [PIXEL_BITS-1:0] lb_rd [NLB];
	pixel_t [WIN-1:0]      colvec;
	logic                  free_s2, adv_s1;

	assign free_s2 = !v_s2_q || free_s3;
	assign adv_s1  = v_s1_q && free_s2;
	assign ready   = !v_s1_q || free_s2;
	assign v_s2    = v_s2_q;
	assign win     = win_q;

	// New window column; with a one-pixel row the buffer read overlaps
	// the write just made, so the value comes from the window instead
	always_comb begin
		colvec[0] = pix_s1;
		for (int k = 0; k < NLB; k++) begin
			colvec[k+1] = fwd_s1 ? win_q[0][k] : pixel_t'(lb_rd[k]);
		end
	end

	// Line buffer chain: buffer k holds the row k+1 above the input
	for (genvar k = 0; k < NLB; k++) begin : g_lb
		mpdwf_ram #(
			.WIDTH (PIXEL_BITS),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (adv_s1),
			.waddr (col_s1),
			.wdata (colvec[k]),
			.re    (accept),
			.raddr (rd_col),
			.rdata (lb_rd[k])
		);
	end

	// Stage s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept) begin
			v_s1_q <= 1'b1;
		end else if (adv_s1) begin
			v_s1_q <= 1'b0;
		end
	end

	// Stage s1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix;
			col_s1  <= rd_col;
			fwd_s1  <= adv_s1 && (rd_col == col_s1);
			ctl_s1  <= ctl;
			rowm_s1 <= rowm;
			colm_s1 <= colm;
		end
	end

	// Stage s2 control: only items that complete a window go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (free_s2) begin
			v_s2_q <= v_s1_q && ctl_s1.emit;
		end
	end

	// Window shift and stage s2 payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0] <= colvec;
			for (int j = 1; j < WIN; j++) begin
				win_q[j] <= win_q[j-1];
			end
			ctl_s2  <= ctl_s1;
			rowm_s2 <= rowm_s1;
			colm_s2 <= colm_s1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mpdwf_select.sv @@
// Minimum search over the window (stage s3) and the result register.
`default_nettype none

module mpdwf_select
	import mpdwf_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                v_s2,
	input  wire pixel_t [2*MAX_RADIUS:0][2*MAX_RADIUS:0] win,
	input  wire ctl_t                                ctl_s2,
	input  wire logic [2*MAX_RADIUS:0]               rowm_s2,
	input  wire logic [2*MAX_RADIUS:0]               colm_s2,
	output logic                                     free_s3,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output res_item_t                                res_data
);

	localparam int WIN = 2 * MAX_RADIUS + 1;

	typedef struct packed {
		logic   found;
		pixel_t px;
	} cand_t;

	// Later candidate wins only on a strictly smaller positive depth,
	// so the earliest pixel in scan order keeps a tie
	function automatic cand_t pick(cand_t best, pixel_t px, logic en);
		cand_t r;
		r = best;
		if (en && px.depth != '0 && (!best.found || px.depth < best.px.depth)) begin
			r.found = 1'b1;
			r.px    = px;
		end
		return r;
	endfunction

	cand_t [WIN-1:0] row_best;
	cand_t [WIN-1:0] row_best_s3;
	pixel_t          centre_s3;
	ctl_t            ctl_s3;
	logic            v_s3_q;
	cand_t           final_best;
	pixel_t          result_px;
	res_item_t       res_q;
	logic            res_valid_q;
	logic            take_out;

	assign take_out  = !res_valid_q || res_ready;
	assign free_s3   = !v_s3_q || take_out;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Per window row: oldest column first, inside the clipped region
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			row_best[k] = '0;
			for (int j = WIN - 1; j >= 0; j--) begin
				row_best[k] = pick(row_best[k], win[j][k], rowm_s2[k] && colm_s2[j]);
			end
		end
	end

	// Across rows, oldest row first
	always_comb begin
		final_best = '0;
		for (int k = WIN - 1; k >= 0; k--) begin
			final_best = pick(final_best, row_best_s3[k].px, row_best_s3[k].found);
		end
		result_px = ctl_s3.pass ? centre_s3 : final_best.px;
	end

	// Stage s3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3_q <= 1'b0;
		end else if (free_s3) begin
			v_s3_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && free_s3) begin
			row_best_s3 <= row_best;
			centre_s3   <= win[0][0];
			ctl_s3      <= ctl_s2;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_out) begin
			res_valid_q <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3_q && take_out) begin
			res_q.depth_out    <= result_px.depth;
			res_q.normal_x_out <= result_px.nx;
			res_q.normal_y_out <= result_px.ny;
			res_q.normal_z_out <= result_px.nz;
			res_q.frame_last   <= ctl_s3.last;
		end
	end

endmodule

`default_nettype wire

@@ test/tb_min_positive_depth_window_filter_unit.sv @@
// Self-checking testbench for the minimum positive depth window filter.
`timescale 1ns / 1ps

module tb_min_positive_depth_window_filter_unit;
	import mpdwf_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned IDLE_PERCENT = 21;

	// Index outside the register map, written to check it is ignored
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

	// Predicts the window minimum for each pixel and holds the results still due
	class erosion_checker;
		localparam int RING_LEN = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
		localparam int MAX_REPORTS = 60;

		pixel_t                 pixel_history [RING_LEN];
		int unsigned            col_pos;
		int unsigned            row_pos;
		logic [RADIUS_BITS-1:0] radius;
		logic [DIM_BITS-1:0]    width_reg;
		logic [DIM_BITS-1:0]    height_reg;
		res_item_t              expected_minima [$];
		int unsigned            mismatches;
		int unsigned            results_seen;
		int unsigned            frames_seen;
		int unsigned            pixels_taken;
		int unsigned            writes_taken;

		function new();
			radius = RADIUS_RESET;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
			results_seen = 0;
			frames_seen = 0;
			pixels_taken = 0;
			writes_taken = 0;
			foreach (pixel_history[i]) pixel_history[i] = '0;
		endfunction

		// Zero reads as one, oversize saturates
		function int unsigned clip_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
			if (v == 0) return 1;
			return (v > hi) ? hi : int'(v);
		endfunction

		function int unsigned eff_radius();
			return (radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius);
		endfunction

		function int unsigned frame_pixels();
			return clip_dim(width_reg, DEF_MAX_WIDTH) * clip_dim(height_reg, MAX_HEIGHT);
		endfunction

		function int unsigned window_lag();
			return eff_radius() * clip_dim(width_reg, DEF_MAX_WIDTH) + eff_radius();
		endfunction

		// Pixels plus the flush needed for the last result of a frame
		function int unsigned frame_items();
			return frame_pixels() + window_lag();
		endfunction

		function void apply_write(logic [CFG_INDEX_BITS-1:0] index,
				logic [CFG_DATA_BITS-1:0] value);
			writes_taken++;
			case (index)
				CFG_KERNEL_RADIUS: radius = value[RADIUS_BITS-1:0];
				CFG_IMAGE_WIDTH:   width_reg = value;
				CFG_IMAGE_HEIGHT:  height_reg = value;
				default:           return;
			endcase
			// any real write restarts the frame
			col_pos = 0;
			row_pos = 0;
		endfunction

		function void take_pixel(px_item_t item);
			int unsigned w, h, rad, n, lag, p, q, r, c, r0, r1, c0, c1, rr, cc;
			pixel_t px, best, cand;
			bit found;
			w = clip_dim(width_reg, DEF_MAX_WIDTH);
			h = clip_dim(height_reg, MAX_HEIGHT);
			rad = eff_radius();
			n = w * h;
			lag = rad * w + rad;
			p = row_pos * w + col_pos;
			pixels_taken++;

			// store only inside the frame; padding counts as an empty pixel
			if (p < n) begin
				if (item.is_padding)
					px = '0;
				else
					px = '{depth: item.depth_in, nx: item.normal_x_in,
						ny: item.normal_y_in, nz: item.normal_z_in};
				pixel_history[p % RING_LEN] = px;
			end

			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end

			// window of the delayed centre is complete
			if (p >= lag && p - lag < n) begin
				q = p - lag;
				r = q / w;
				c = q % w;
				best = '0;
				if (rad == 0) begin
					best = pixel_history[q % RING_LEN];
				end else begin
					found = 1'b0;
					r0 = (r >= rad) ? r - rad : 0;
					r1 = (r + rad < h) ? r + rad : h - 1;
					c0 = (c >= rad) ? c - rad : 0;
					c1 = (c + rad < w) ? c + rad : w - 1;
					for (rr = r0; rr <= r1; rr++) begin
						for (cc = c0; cc <= c1; cc++) begin
							cand = pixel_history[(rr * w + cc) % RING_LEN];
							// strict less-than keeps the earliest on a tie
							if (cand.depth != 0 && (!found || cand.depth < best.depth)) begin
								best = cand;
								found = 1'b1;
							end
						end
					end
				end
				expected_minima.push_back('{depth_out: best.depth, normal_x_out: best.nx,
					normal_y_out: best.ny, normal_z_out: best.nz,
					frame_last: (q == n - 1)});
				if (q == n - 1) begin
					col_pos = 0;
					row_pos = 0;
				end
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			results_seen++;
			if (expected_minima.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result expected none, got %h", $time, got);
				return;
			end
			want = expected_minima.pop_front();
			compare_field("depth_out", want.depth_out, got.depth_out);
			compare_field("normal_x_out", want.normal_x_out, got.normal_x_out);
			compare_field("normal_y_out", want.normal_y_out, got.normal_y_out);
			compare_field("normal_z_out", want.normal_z_out, got.normal_z_out);
			compare_field("frame_last", 16'(want.frame_last), 16'(got.frame_last));
			if (got.frame_last === 1'b1) frames_seen++;
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      px_valid = 1'b0;
	logic                      px_ready;
	px_item_t                  px_data = '0;
	logic                      res_valid;
	logic                      res_ready = 1'b0;
	res_item_t                 res_data;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	bit                        no_idle = 1'b0;
	int unsigned               cycle_count = 0;
	int unsigned               random_items = 0;
	erosion_checker            erosion = new();

	min_positive_depth_window_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px_data   (px_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		res_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Transaction monitor: config, then pixels, then results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) erosion.apply_write(cfg_index, cfg_data);
			if (px_valid && px_ready) erosion.take_pixel(px_data);
			if (res_valid && res_ready) erosion.check_result(res_data);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic px_item_t make_pixel(logic [15:0] d, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic pad);
		return '{depth_in: d, normal_x_in: x, normal_y_in: y, normal_z_in: z, is_padding: pad};
	endfunction

	function automatic logic [15:0] random_normal();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Many zeros and small depths so that ties and empty windows come up
	function automatic px_item_t random_pixel(bit flushing);
		logic [15:0] d;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25)      d = 16'd0;
		else if (pick < 45) d = 16'($urandom_range(1, 4));
		else if (pick < 52) d = 16'hffff;
		else if (pick < 56) d = 16'd1;
		else                d = 16'($urandom);
		return make_pixel(d, random_normal(), random_normal(), random_normal(),
			flushing ? ($urandom_range(99) < 80) : ($urandom_range(99) < 5));
	endfunction

	task automatic drive_pixel(input px_item_t item);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			px_valid <= 1'b0;
			@(negedge clk);
		end
		px_valid <= 1'b1;
		px_data <= item;
		do @(posedge clk); while (!px_ready);
		@(negedge clk);
	endtask

	task automatic stream_frame(input int unsigned count);
		int unsigned pixels;
		pixels = erosion.frame_pixels();
		for (int unsigned i = 0; i < count; i++)
			drive_pixel(random_pixel(i >= pixels));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [RADIUS_BITS-1:0] rad, input logic [DIM_BITS-1:0] w,
			input logic [DIM_BITS-1:0] h, input logic [2:0] mask);
		if (mask[0]) write_reg(CFG_KERNEL_RADIUS, CFG_DATA_BITS'(rad));
		if (mask[1]) write_reg(CFG_IMAGE_WIDTH, w);
		if (mask[2]) write_reg(CFG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Wait for outstanding results, then let the pipeline empty
	task automatic wait_drained();
		while (erosion.expected_minima.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned frames, cut;
		logic [RADIUS_BITS-1:0] rad;
		logic [DIM_BITS-1:0] w, h;
		logic [2:0] mask;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a few pixels at the reset geometry; the write below aborts that frame
		repeat (4) drive_pixel(random_pixel(1'b0));
		px_valid <= 1'b0;
		wait_drained();

		// 3x3, radius 1: extremes, ties, padding inside the frame, pixels in the flush
		configure(2'd1, 11'd3, 11'd3, 3'b111);
		drive_pixel(make_pixel(16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
		drive_pixel(make_pixel(16'hffff, 16'h8000, 16'h8000, 16'h8000, 1'b0));
		drive_pixel(make_pixel(16'd5, 16'd1, 16'd2, 16'd3, 1'b0));
		drive_pixel(make_pixel(16'd5, 16'd4, 16'd5, 16'd6, 1'b0));
		drive_pixel(make_pixel(16'd1, 16'h1111, 16'h2222, 16'h3333, 1'b1));
		drive_pixel(make_pixel(16'd3, 16'hfff0, 16'h000f, 16'h8001, 1'b0));
		drive_pixel(make_pixel(16'hffff, 16'h0001, 16'hffff, 16'h4000, 1'b0));
		drive_pixel(make_pixel(16'd3, 16'd7, 16'd7, 16'd7, 1'b0));
		drive_pixel(make_pixel(16'd0, 16'd9, 16'd9, 16'd9, 1'b0));
		drive_pixel(make_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
		drive_pixel(make_pixel(16'd1, 16'habcd, 16'h1234, 16'h5678, 1'b0));
		drive_pixel(make_pixel(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
		drive_pixel(make_pixel(16'd2, 16'h7fff, 16'h8000, 16'h0000, 1'b0));
		px_valid <= 1'b0;
		wait_drained();

		// pass through: zero depth keeps its normal, padding becomes zero
		configure(2'd0, 11'd2, 11'd2, 3'b111);
		drive_pixel(make_pixel(16'd0, 16'h1234, 16'h8000, 16'h7fff, 1'b0));
		drive_pixel(make_pixel(16'hffff, 16'h7fff, 16'h0001, 16'h8000, 1'b0));
		drive_pixel(make_pixel(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1));
		drive_pixel(make_pixel(16'd1, 16'hffff, 16'h0000, 16'h0001, 1'b0));
		px_valid <= 1'b0;
		wait_drained();

		// radius 3 on a 2x1 frame of zero depths, too short to flush; the next write aborts it
		configure(2'd3, 11'd2, 11'd1, 3'b111);
		drive_pixel(make_pixel(16'd0, 16'h1234, 16'h5678, 16'h9abc, 1'b0));
		drive_pixel(make_pixel(16'd0, 16'h8000, 16'h7fff, 16'h0001, 1'b0));
		repeat (5) drive_pixel(random_pixel(1'b1));
		px_valid <= 1'b0;
		wait_drained();

		// largest height (width zero reads as one), with no idling on either side
		no_idle = 1'b1;
		configure(2'd3, 11'd0, 11'd1100, 3'b111);
		stream_frame(erosion.frame_items());
		px_valid <= 1'b0;
		wait_drained();
		no_idle = 1'b0;

		// random geometries, back-to-back frames and aborted frames
		while (random_items < RANDOM_ITEMS) begin
			rad = RADIUS_BITS'($urandom_range(3));
			case ($urandom_range(19))
				0:       w = 11'd0;
				1, 2:    w = DIM_BITS'($urandom_range(13, 40));
				default: w = DIM_BITS'($urandom_range(1, 12));
			endcase
			case ($urandom_range(19))
				0:       h = 11'd0;
				1:       h = DIM_BITS'($urandom_range(9, 16));
				default: h = DIM_BITS'($urandom_range(1, 8));
			endcase
			mask = (random_items == 0) ? 3'b111 : 3'($urandom_range(1, 7));
			configure(rad, w, h, mask);

			frames = $urandom_range(1, 3);
			repeat (frames) begin
				stream_frame(erosion.frame_items());
				random_items += erosion.frame_items();
			end
			if ($urandom_range(99) < 20 && erosion.frame_items() > 1) begin
				cut = $urandom_range(1, erosion.frame_items() - 1);
				stream_frame(cut);
				random_items += cut;
				if ($urandom_range(1) == 1) begin
					// unmapped index must leave the cursor where it is
					px_valid <= 1'b0;
					wait_drained();
					write_reg(CFG_UNUSED_INDEX, CFG_DATA_BITS'($urandom));
					cfg_valid <= 1'b0;
					stream_frame(erosion.frame_items());
					random_items += erosion.frame_items();
				end
			end
			px_valid <= 1'b0;
			wait_drained();
		end

		erosion.mismatches += erosion.expected_minima.size();
		if (erosion.expected_minima.size() != 0)
			$display("%0t: %0d results expected, never received", $time,
				erosion.expected_minima.size());
		$display("Covered %0d pixel transactions, %0d results, %0d frames, %0d register writes,",
			erosion.pixels_taken, erosion.results_seen, erosion.frames_seen,
			erosion.writes_taken);
		$display("radius 0 to 3, border clipping, ties, padding, flush and aborted frames.");
		if (erosion.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/mpdwf_pkg.sv
rtl/core/mpdwf_ram.sv
rtl/core/mpdwf_ctrl.sv
rtl/core/mpdwf_window.sv
rtl/core/mpdwf_select.sv
rtl/core/min_positive_depth_window_filter_unit.sv
test/tb_min_positive_depth_window_filter_unit.sv
